[src/hmsg_pkg.sv]
// ----------------------------------------------------------------------------
// hmsg_pkg: shared types and constants for the H-bridge mode/stall guard
// Mode and command codes, configuration and status bundles, PWM scaling
// constants.
// ----------------------------------------------------------------------------
package hmsg_pkg;

  localparam int ADC_BITS_DFLT  = 12;
  localparam int TIME_BITS_DFLT = 16;

  localparam int DUTY_W   = 10;
  localparam int MS_W     = 16;
  localparam int THR_W    = 12;
  localparam int PBITS_W  = 5;
  localparam int PWM_W    = 16;
  localparam int CUR_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [DUTY_W-1:0] DUTY_FULL = 10'd1000;

  // floor(p / 1000) == (p * RECIP_M) >> RECIP_S for any p below 2^PROD_W
  localparam int PROD_W  = DUTY_W + PWM_W;
  localparam int RECIP_S = 36;
  localparam int RECIP_W = 27;
  localparam logic [RECIP_W-1:0] RECIP_M = 27'd68719477;

  localparam logic [PBITS_W-1:0] PWM_BITS_RST = 5'd8;
  localparam logic [THR_W-1:0]   THR_RST      = 12'd4095;

  typedef enum logic [1:0] {
    MODE_DISABLED = 2'd0,
    MODE_COAST    = 2'd1,
    MODE_BRAKE    = 2'd2,
    MODE_RUN      = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    FUNC_TICK        = 3'd0,
    FUNC_ENABLE      = 3'd1,
    FUNC_DISABLE     = 3'd2,
    FUNC_RUN         = 3'd3,
    FUNC_COAST       = 3'd4,
    FUNC_BRAKE       = 3'd5,
    FUNC_CLEAR_FAULT = 3'd6
  } func_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PWM_BITS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SS_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SS_DUTY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SS_MS         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BLANKING_MS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_HOLD_MS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_THR     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_STALL_PROT    = 3'd7;

  typedef struct packed {
    logic [PBITS_W-1:0] pwm_bits;
    logic               ss_enable;
    logic [DUTY_W-1:0]  ss_duty;
    logic [MS_W-1:0]    ss_ms;
    logic [MS_W-1:0]    blanking_ms;
    logic [MS_W-1:0]    stall_hold_ms;
    logic [THR_W-1:0]   stall_thr;
    logic               stall_prot;
  } cfg_t;

  typedef struct packed {
    logic              coast_pin;
    mode_t             mode;
    logic              enabled;
    logic              fault;
    logic              stall_event;
    logic              kick;
    logic [DUTY_W-1:0] applied_duty;
  } stat_t;

endpackage

[src/hmsg_ctrl.sv]
// ----------------------------------------------------------------------------
// hmsg_ctrl: drive mode, duty and stall timer state
// Applies one command or tick per step and presents the resulting status.
// ----------------------------------------------------------------------------
module hmsg_ctrl #(
  parameter int ADC_BITS  = hmsg_pkg::ADC_BITS_DFLT,
  parameter int TIME_BITS = hmsg_pkg::TIME_BITS_DFLT
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [2:0]                    func,
  input  logic [hmsg_pkg::DUTY_W-1:0]   duty,
  input  logic [hmsg_pkg::CUR_W-1:0]    current_raw,
  input  hmsg_pkg::cfg_t                cfg,
  output hmsg_pkg::stat_t               status
);

  localparam int CMP_W = (ADC_BITS < hmsg_pkg::CUR_W) ? ADC_BITS : hmsg_pkg::CUR_W;
  localparam int TW    = (TIME_BITS > hmsg_pkg::MS_W) ? TIME_BITS : hmsg_pkg::MS_W;

  hmsg_pkg::mode_t               mode_r, mode_nxt;
  logic                          en_r, en_nxt;
  logic                          fault_r, fault_nxt;
  logic [hmsg_pkg::DUTY_W-1:0]   req_r, req_nxt;
  logic [hmsg_pkg::DUTY_W-1:0]   applied_r, applied_nxt;
  logic                          kick_r, kick_nxt;
  logic [TIME_BITS-1:0]          run_el_r, run_el_nxt;
  logic                          trk_r, trk_nxt;
  logic [TIME_BITS-1:0]          over_r, over_nxt;
  logic                          coast_r, coast_nxt;
  logic                          event_c;
  logic [hmsg_pkg::DUTY_W-1:0]   duty_sat;
  logic [hmsg_pkg::DUTY_W-1:0]   ss_duty_sat;
  logic                          over_thr;

  assign duty_sat    = (duty > hmsg_pkg::DUTY_FULL) ? hmsg_pkg::DUTY_FULL : duty;
  assign ss_duty_sat = (cfg.ss_duty > hmsg_pkg::DUTY_FULL) ? hmsg_pkg::DUTY_FULL
                                                           : cfg.ss_duty;
  assign over_thr    = current_raw[CMP_W-1:0] > cfg.stall_thr[CMP_W-1:0];

  always_comb begin
    mode_nxt    = mode_r;
    en_nxt      = en_r;
    fault_nxt   = fault_r;
    req_nxt     = req_r;
    applied_nxt = applied_r;
    kick_nxt    = kick_r;
    run_el_nxt  = run_el_r;
    trk_nxt     = trk_r;
    over_nxt    = over_r;
    coast_nxt   = coast_r;
    event_c     = 1'b0;
    unique case (func)
      hmsg_pkg::FUNC_TICK: begin
        if (mode_r == hmsg_pkg::MODE_RUN) begin
          run_el_nxt = (&run_el_r) ? run_el_r : run_el_r + TIME_BITS'(1);
          if (kick_r && (TW'(run_el_nxt) >= TW'(cfg.ss_ms))) begin
            kick_nxt    = 1'b0;
            applied_nxt = req_r;
          end
        end
        if (!cfg.stall_prot || (mode_r != hmsg_pkg::MODE_RUN) ||
            (TW'(run_el_nxt) < TW'(cfg.blanking_ms)) || !over_thr) begin
          trk_nxt  = 1'b0;
          over_nxt = '0;
        end else if (!trk_r) begin
          trk_nxt  = 1'b1;
          over_nxt = '0;
        end else begin
          over_nxt = (&over_r) ? over_r : over_r + TIME_BITS'(1);
          if (TW'(over_nxt) >= TW'(cfg.stall_hold_ms)) begin
            // latch the fault and fall back to coast
            fault_nxt   = 1'b1;
            coast_nxt   = 1'b1;
            applied_nxt = '0;
            kick_nxt    = 1'b0;
            mode_nxt    = en_r ? hmsg_pkg::MODE_COAST : hmsg_pkg::MODE_DISABLED;
            trk_nxt     = 1'b0;
            over_nxt    = '0;
            event_c     = 1'b1;
          end
        end
      end
      hmsg_pkg::FUNC_ENABLE: begin
        en_nxt = 1'b1;
        if (mode_r == hmsg_pkg::MODE_DISABLED) begin
          coast_nxt   = 1'b1;
          applied_nxt = '0;
          kick_nxt    = 1'b0;
          mode_nxt    = hmsg_pkg::MODE_COAST;
          trk_nxt     = 1'b0;
          over_nxt    = '0;
        end
      end
      hmsg_pkg::FUNC_DISABLE: begin
        coast_nxt   = 1'b1;
        req_nxt     = '0;
        applied_nxt = '0;
        kick_nxt    = 1'b0;
        en_nxt      = 1'b0;
        mode_nxt    = hmsg_pkg::MODE_DISABLED;
        trk_nxt     = 1'b0;
        over_nxt    = '0;
      end
      hmsg_pkg::FUNC_RUN: begin
        if (!fault_r) begin
          en_nxt     = 1'b1;
          req_nxt    = duty_sat;
          run_el_nxt = '0;
          trk_nxt    = 1'b0;
          over_nxt   = '0;
          coast_nxt  = 1'b0;
          if (cfg.ss_enable && (duty_sat != '0) && (duty_sat < cfg.ss_duty) &&
              (cfg.ss_ms != '0)) begin
            kick_nxt    = 1'b1;
            applied_nxt = ss_duty_sat;
          end else begin
            kick_nxt    = 1'b0;
            applied_nxt = duty_sat;
          end
          mode_nxt = hmsg_pkg::MODE_RUN;
        end
      end
      hmsg_pkg::FUNC_COAST, hmsg_pkg::FUNC_BRAKE: begin
        coast_nxt   = (func == hmsg_pkg::FUNC_COAST);
        applied_nxt = '0;
        kick_nxt    = 1'b0;
        if (!en_r) begin
          mode_nxt = hmsg_pkg::MODE_DISABLED;
        end else if (func == hmsg_pkg::FUNC_COAST) begin
          mode_nxt = hmsg_pkg::MODE_COAST;
        end else begin
          mode_nxt = hmsg_pkg::MODE_BRAKE;
        end
        trk_nxt  = 1'b0;
        over_nxt = '0;
      end
      hmsg_pkg::FUNC_CLEAR_FAULT: begin
        fault_nxt = 1'b0;
        trk_nxt   = 1'b0;
        over_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= hmsg_pkg::MODE_COAST;
      en_r      <= 1'b0;
      fault_r   <= 1'b0;
      req_r     <= '0;
      applied_r <= '0;
      kick_r    <= 1'b0;
      run_el_r  <= '0;
      trk_r     <= 1'b0;
      over_r    <= '0;
      coast_r   <= 1'b1;
    end else if (step) begin
      mode_r    <= mode_nxt;
      en_r      <= en_nxt;
      fault_r   <= fault_nxt;
      req_r     <= req_nxt;
      applied_r <= applied_nxt;
      kick_r    <= kick_nxt;
      run_el_r  <= run_el_nxt;
      trk_r     <= trk_nxt;
      over_r    <= over_nxt;
      coast_r   <= coast_nxt;
    end
  end

  always_comb begin
    status.coast_pin    = coast_nxt;
    status.mode         = mode_nxt;
    status.enabled      = en_nxt;
    status.fault        = fault_nxt;
    status.stall_event  = event_c;
    status.kick         = kick_nxt;
    status.applied_duty = applied_nxt;
  end

endmodule

[src/hbridge_mode_stall_guard_unit.sv]
// ----------------------------------------------------------------------------
// hbridge_mode_stall_guard_unit: H-bridge mode controller with stall guard
// Takes commands and 1 ms current ticks, returns PWM compare and status.
// ----------------------------------------------------------------------------
// Accepts one item per clock while in_ready is high and returns exactly one
// result item for each, in order. The state update happens in the cycle the
// item is accepted; the result then passes through three registered stages
// (s1, s2, out) on its way to the out_ channel. The stages serve the PWM
// scaling: duty times full scale is one registered multiply, and the
// divide by 1000 is a second registered multiply by a fixed reciprocal. Each
// stage holds its item while the next is full, so a stalled output backs up
// at most three items before in_ready drops. in_ready stays low while reset
// is held. Configuration writes take effect on the next edge and are meant
// to be issued while no item is in flight.
// ----------------------------------------------------------------------------
module hbridge_mode_stall_guard_unit #(
  parameter int ADC_BITS  = hmsg_pkg::ADC_BITS_DFLT,
  parameter int TIME_BITS = hmsg_pkg::TIME_BITS_DFLT
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [hmsg_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [hmsg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [2:0]                        in_func,
  input  logic [hmsg_pkg::DUTY_W-1:0]       in_duty,
  input  logic [hmsg_pkg::CUR_W-1:0]        in_current_raw,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [hmsg_pkg::PWM_W-1:0]        out_pwm_compare,
  output logic                              out_coast_pin,
  output logic [1:0]                        out_mode_now,
  output logic                              out_is_enabled,
  output logic                              out_fault_latched,
  output logic                              out_stall_event,
  output logic                              out_kick_active,
  output logic [hmsg_pkg::DUTY_W-1:0]       out_applied_duty
);

  localparam int PROD_W  = hmsg_pkg::PROD_W;
  localparam int RPROD_W = hmsg_pkg::PROD_W + hmsg_pkg::RECIP_W;

  hmsg_pkg::cfg_t   cfg_r;
  hmsg_pkg::stat_t  stat_c;
  hmsg_pkg::stat_t  s1_st_r, s2_st_r, out_st_r;
  logic [hmsg_pkg::PWM_W-1:0]   s1_full_r;
  logic [PROD_W-1:0]            s2_prod_r;
  logic [hmsg_pkg::PWM_W-1:0]   out_pwm_r;
  logic                         s1_valid_r, s2_valid_r, out_valid_r;
  logic                         out_load, s2_load, s1_load, accept;
  logic [hmsg_pkg::PBITS_W-1:0] bits_c;
  logic [hmsg_pkg::PWM_W:0]     full_c;
  logic [RPROD_W-1:0]           rprod_c;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pwm_bits      <= hmsg_pkg::PWM_BITS_RST;
      cfg_r.ss_enable     <= 1'b0;
      cfg_r.ss_duty       <= '0;
      cfg_r.ss_ms         <= '0;
      cfg_r.blanking_ms   <= '0;
      cfg_r.stall_hold_ms <= '0;
      cfg_r.stall_thr     <= hmsg_pkg::THR_RST;
      cfg_r.stall_prot    <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        hmsg_pkg::CFG_PWM_BITS:      cfg_r.pwm_bits <= cfg_wdata[hmsg_pkg::PBITS_W-1:0];
        hmsg_pkg::CFG_SS_ENABLE:     cfg_r.ss_enable <= cfg_wdata[0];
        hmsg_pkg::CFG_SS_DUTY:       cfg_r.ss_duty <= cfg_wdata[hmsg_pkg::DUTY_W-1:0];
        hmsg_pkg::CFG_SS_MS:         cfg_r.ss_ms <= cfg_wdata[hmsg_pkg::MS_W-1:0];
        hmsg_pkg::CFG_BLANKING_MS:   cfg_r.blanking_ms <= cfg_wdata[hmsg_pkg::MS_W-1:0];
        hmsg_pkg::CFG_STALL_HOLD_MS: cfg_r.stall_hold_ms <= cfg_wdata[hmsg_pkg::MS_W-1:0];
        hmsg_pkg::CFG_STALL_THR:     cfg_r.stall_thr <= cfg_wdata[hmsg_pkg::THR_W-1:0];
        hmsg_pkg::CFG_STALL_PROT:    cfg_r.stall_prot <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // stage enables: a stage loads when empty or when its item moves on
  assign out_load = !out_valid_r || out_ready;
  assign s2_load  = !s2_valid_r || out_load;
  assign s1_load  = !s1_valid_r || s2_load;
  // hold off new items while reset is asserted
  assign in_ready = s1_load && rst_n;
  assign accept   = in_valid && in_ready;

  hmsg_ctrl #(
    .ADC_BITS  (ADC_BITS),
    .TIME_BITS (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (accept),
    .func        (in_func),
    .duty        (in_duty),
    .current_raw (in_current_raw),
    .cfg         (cfg_r),
    .status      (stat_c)
  );

  // full scale = 2^bits - 1, with bits clamped to 16
  assign bits_c  = (cfg_r.pwm_bits > hmsg_pkg::PBITS_W'(hmsg_pkg::PWM_W))
                   ? hmsg_pkg::PBITS_W'(hmsg_pkg::PWM_W) : cfg_r.pwm_bits;
  assign full_c  = ((hmsg_pkg::PWM_W+1)'(1) << bits_c) - (hmsg_pkg::PWM_W+1)'(1);
  assign rprod_c = RPROD_W'(s2_prod_r) * RPROD_W'(hmsg_pkg::RECIP_M);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_r <= in_valid;
      end
      if (s2_load) begin
        s2_valid_r <= s1_valid_r;
      end
      if (out_load) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // payload: hold status alongside the PWM product
  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_st_r   <= stat_c;
      s1_full_r <= full_c[hmsg_pkg::PWM_W-1:0];
    end
    if (s2_load) begin
      s2_st_r   <= s1_st_r;
      s2_prod_r <= PROD_W'(s1_st_r.applied_duty) * PROD_W'(s1_full_r);
    end
    if (out_load) begin
      out_st_r  <= s2_st_r;
      out_pwm_r <= rprod_c[hmsg_pkg::RECIP_S +: hmsg_pkg::PWM_W];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_pwm_compare   = out_pwm_r;
  assign out_coast_pin     = out_st_r.coast_pin;
  assign out_mode_now      = out_st_r.mode;
  assign out_is_enabled    = out_st_r.enabled;
  assign out_fault_latched = out_st_r.fault;
  assign out_stall_event   = out_st_r.stall_event;
  assign out_kick_active   = out_st_r.kick;
  assign out_applied_duty  = out_st_r.applied_duty;

endmodule

[tb/hbridge_guard_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbridge_guard_checker: result predictor and scoreboard for the H-bridge guard
// Follows configuration writes and accepted input items, predicts the status
// item each one returns and compares every returned item field by field.
// ----------------------------------------------------------------------------
module hbridge_guard_checker import hmsg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic [2:0]            in_func,
  input  logic [DUTY_W-1:0]     in_duty,
  input  logic [CUR_W-1:0]      in_current_raw,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [PWM_W-1:0]      out_pwm_compare,
  input  logic                  out_coast_pin,
  input  logic [1:0]            out_mode_now,
  input  logic                  out_is_enabled,
  input  logic                  out_fault_latched,
  input  logic                  out_stall_event,
  input  logic                  out_kick_active,
  input  logic [DUTY_W-1:0]     out_applied_duty,
  output int                    mismatches,
  output int                    outstanding,
  output int                    stalls_seen
);

  typedef struct {
    mode_t             mode;
    logic              en;
    logic              fault;
    logic [DUTY_W-1:0] req;
    logic [DUTY_W-1:0] app;
    logic              kick;
    logic [MS_W-1:0]   run_t;
    logic              track;
    logic [MS_W-1:0]   over_t;
    logic              coast;
  } bridge_state_t;

  typedef struct {
    logic [PWM_W-1:0]  pwm;
    logic              coast;
    mode_t             mode;
    logic              en;
    logic              fault;
    logic              evt;
    logic              kick;
    logic [DUTY_W-1:0] duty;
  } bridge_status_t;

  bridge_state_t  st;
  cfg_t           cfg;
  bridge_status_t status_due_q[$];
  bridge_status_t want;

  function automatic logic [DUTY_W-1:0] clip_duty(logic [DUTY_W-1:0] d);
    return (d > DUTY_FULL) ? DUTY_FULL : d;
  endfunction

  function automatic logic [MS_W-1:0] sat_up(logic [MS_W-1:0] t);
    return (t == '1) ? t : t + 1'b1;
  endfunction

  function automatic void drop_tracking();
    st.track  = 1'b0;
    st.over_t = '0;
  endfunction

  function automatic void halt_drive(logic level, mode_t mode_if_en);
    st.coast = level;
    st.app   = '0;
    st.kick  = 1'b0;
    st.mode  = st.en ? mode_if_en : MODE_DISABLED;
    drop_tracking();
  endfunction

  function automatic void grant_enable();
    st.en = 1'b1;
    if (st.mode == MODE_DISABLED) halt_drive(1'b1, MODE_COAST);
  endfunction

  function automatic bridge_status_t bridge_step(logic [2:0] f, logic [DUTY_W-1:0] d,
                                                 logic [CUR_W-1:0] c);
    bridge_status_t r;
    logic           evt;
    int unsigned    nb;
    int unsigned    fs;
    evt = 1'b0;
    case (f)
      FUNC_TICK: begin
        if (st.mode == MODE_RUN) begin
          st.run_t = sat_up(st.run_t);
          if (st.kick && st.run_t >= cfg.ss_ms) begin
            st.kick = 1'b0;
            st.app  = st.req;
          end
        end
        if (!cfg.stall_prot || st.mode != MODE_RUN || st.run_t < cfg.blanking_ms ||
            c <= cfg.stall_thr) begin
          drop_tracking();
        end else if (!st.track) begin
          st.track  = 1'b1;
          st.over_t = '0;
        end else begin
          st.over_t = sat_up(st.over_t);
          if (st.over_t >= cfg.stall_hold_ms) begin
            st.fault = 1'b1;
            halt_drive(1'b1, MODE_COAST);
            evt = 1'b1;
          end
        end
      end
      FUNC_ENABLE: grant_enable();
      FUNC_DISABLE: begin
        st.coast = 1'b1;
        st.req   = '0;
        st.app   = '0;
        st.kick  = 1'b0;
        st.en    = 1'b0;
        st.mode  = MODE_DISABLED;
        drop_tracking();
      end
      FUNC_RUN: begin
        if (!st.fault) begin
          if (!st.en) grant_enable();
          st.req   = clip_duty(d);
          st.run_t = '0;
          drop_tracking();
          st.coast = 1'b0;
          if (cfg.ss_enable && st.req > 0 && st.req < cfg.ss_duty && cfg.ss_ms > 0) begin
            st.kick = 1'b1;
            st.app  = clip_duty(cfg.ss_duty);
          end else begin
            st.kick = 1'b0;
            st.app  = st.req;
          end
          st.mode = MODE_RUN;
        end
      end
      FUNC_COAST:       halt_drive(1'b1, MODE_COAST);
      FUNC_BRAKE:       halt_drive(1'b0, MODE_BRAKE);
      FUNC_CLEAR_FAULT: begin
        st.fault = 1'b0;
        drop_tracking();
      end
      default: ;
    endcase
    nb      = (cfg.pwm_bits > 16) ? 16 : cfg.pwm_bits;
    fs      = (32'd1 << nb) - 1;
    r.pwm   = PWM_W'((st.app * fs) / 1000);
    r.coast = st.coast;
    r.mode  = st.mode;
    r.en    = st.en;
    r.fault = st.fault;
    r.evt   = evt;
    r.kick  = st.kick;
    r.duty  = st.app;
    return r;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned got_v);
    if (exp_v != got_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      st.mode   = MODE_COAST;
      st.en     = 1'b0;
      st.fault  = 1'b0;
      st.req    = '0;
      st.app    = '0;
      st.kick   = 1'b0;
      st.run_t  = '0;
      st.track  = 1'b0;
      st.over_t = '0;
      st.coast  = 1'b1;
      cfg       = '0;
      cfg.pwm_bits  = PWM_BITS_RST;
      cfg.stall_thr = THR_RST;
      status_due_q.delete();
      mismatches  = 0;
      stalls_seen = 0;
      outstanding <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          CFG_PWM_BITS:      cfg.pwm_bits      = cfg_wdata[PBITS_W-1:0];
          CFG_SS_ENABLE:     cfg.ss_enable     = cfg_wdata[0];
          CFG_SS_DUTY:       cfg.ss_duty       = cfg_wdata[DUTY_W-1:0];
          CFG_SS_MS:         cfg.ss_ms         = cfg_wdata[MS_W-1:0];
          CFG_BLANKING_MS:   cfg.blanking_ms   = cfg_wdata[MS_W-1:0];
          CFG_STALL_HOLD_MS: cfg.stall_hold_ms = cfg_wdata[MS_W-1:0];
          CFG_STALL_THR:     cfg.stall_thr     = cfg_wdata[THR_W-1:0];
          CFG_STALL_PROT:    cfg.stall_prot    = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        want = bridge_step(in_func, in_duty, in_current_raw);
        if (want.evt) stalls_seen++;
        status_due_q.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (status_due_q.size() == 0) begin
          $display("%0t: result item arrived with nothing expected", $time);
          mismatches++;
        end else begin
          want = status_due_q.pop_front();
          check_field("pwm_compare", want.pwm, out_pwm_compare);
          check_field("coast_pin", want.coast, out_coast_pin);
          check_field("mode_now", want.mode, out_mode_now);
          check_field("is_enabled", want.en, out_is_enabled);
          check_field("fault_latched", want.fault, out_fault_latched);
          check_field("stall_event", want.evt, out_stall_event);
          check_field("kick_active", want.kick, out_kick_active);
          check_field("applied_duty", want.duty, out_applied_duty);
        end
      end
      outstanding <= status_due_q.size();
    end
  end

endmodule

[tb/tb_hbridge_mode_stall_guard_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hbridge_mode_stall_guard_unit: regression for the H-bridge mode guard
// Drives command and tick items under several register settings, with random
// idling on both channels, and leaves prediction and comparison to the
// checker instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_hbridge_mode_stall_guard_unit;
  import hmsg_pkg::*;

  // Unused command code; the block must pass its state through unchanged.
  localparam logic [2:0] FUNC_UNUSED = 3'd7;
  localparam int RAND_PHASES     = 8;
  localparam int ITEMS_PER_PHASE = 175;
  localparam int HOLD_CYCLES     = 60;

  logic                  clk;
  logic                  rst_n          = 1'b0;
  logic                  cfg_we         = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx        = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata      = '0;
  logic                  in_valid       = 1'b0;
  logic                  in_ready;
  logic [2:0]            in_func        = '0;
  logic [DUTY_W-1:0]     in_duty        = '0;
  logic [CUR_W-1:0]      in_current_raw = '0;
  logic                  out_valid;
  logic                  out_ready      = 1'b0;
  logic [PWM_W-1:0]      out_pwm_compare;
  logic                  out_coast_pin;
  logic [1:0]            out_mode_now;
  logic                  out_is_enabled;
  logic                  out_fault_latched;
  logic                  out_stall_event;
  logic                  out_kick_active;
  logic [DUTY_W-1:0]     out_applied_duty;

  int   mismatches;
  int   outstanding;
  int   stalls_seen;

  // Channel behavior knobs, shared between the stimulus and the receiver.
  bit   tx_steady = 1'b0;
  bit   rx_steady = 1'b0;
  bit   hold_req  = 1'b0;
  int   hold_left = 0;

  cfg_t now_cfg;
  int   items_sent = 0;

  hbridge_mode_stall_guard_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_duty           (in_duty),
    .in_current_raw    (in_current_raw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pwm_compare   (out_pwm_compare),
    .out_coast_pin     (out_coast_pin),
    .out_mode_now      (out_mode_now),
    .out_is_enabled    (out_is_enabled),
    .out_fault_latched (out_fault_latched),
    .out_stall_event   (out_stall_event),
    .out_kick_active   (out_kick_active),
    .out_applied_duty  (out_applied_duty)
  );

  hbridge_guard_checker chk (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_duty           (in_duty),
    .in_current_raw    (in_current_raw),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_pwm_compare   (out_pwm_compare),
    .out_coast_pin     (out_coast_pin),
    .out_mode_now      (out_mode_now),
    .out_is_enabled    (out_is_enabled),
    .out_fault_latched (out_fault_latched),
    .out_stall_event   (out_stall_event),
    .out_kick_active   (out_kick_active),
    .out_applied_duty  (out_applied_duty),
    .mismatches        (mismatches),
    .outstanding       (outstanding),
    .stalls_seen       (stalls_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Receiver: random back-pressure, a steady stretch on request, and a long
  // hold-off counted here so the block fills up and drops in_ready.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (rx_steady) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= 35);
      end
    end
  end

  // Offer one item and hold it until accepted. Idle cycles go in front of the
  // item, so valid is only lowered in a step where it is not raised.
  task automatic push_item(input logic [2:0] f, input logic [DUTY_W-1:0] d,
                           input logic [CUR_W-1:0] c);
    while (!tx_steady && $urandom_range(0, 99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_func        <= f;
    in_duty        <= d;
    in_current_raw <= c;
    do @(posedge clk); while (!in_ready);
    items_sent++;
  endtask

  // Drop valid, wait until every expected result has come back and the
  // three-stage output pipe is empty, then idle before touching registers.
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t c);
    put_reg(CFG_PWM_BITS, CFG_DATA_W'(c.pwm_bits));
    put_reg(CFG_SS_ENABLE, CFG_DATA_W'(c.ss_enable));
    put_reg(CFG_SS_DUTY, CFG_DATA_W'(c.ss_duty));
    put_reg(CFG_SS_MS, c.ss_ms);
    put_reg(CFG_BLANKING_MS, c.blanking_ms);
    put_reg(CFG_STALL_HOLD_MS, c.stall_hold_ms);
    put_reg(CFG_STALL_THR, CFG_DATA_W'(c.stall_thr));
    put_reg(CFG_STALL_PROT, CFG_DATA_W'(c.stall_prot));
    cfg_we  <= 1'b0;
    now_cfg  = c;
  endtask

  // Per-phase settings: short timers mostly, so kicks end and stalls trip,
  // with one phase pinned to each extreme of the wider registers.
  function automatic cfg_t pick_settings(int ph);
    cfg_t c;
    c.pwm_bits      = PBITS_W'($urandom_range(0, 31));
    c.ss_enable     = ($urandom_range(0, 3) != 0);
    c.ss_duty       = DUTY_W'($urandom_range(0, 1023));
    c.ss_ms         = MS_W'($urandom_range(0, 6));
    c.blanking_ms   = MS_W'($urandom_range(0, 5));
    c.stall_hold_ms = MS_W'($urandom_range(0, 5));
    c.stall_thr     = THR_W'($urandom_range(0, 4095));
    c.stall_prot    = ($urandom_range(0, 7) != 0);
    case (ph)
      0: begin
        c.pwm_bits = 5'd0;
        c.ss_enable = 1'b0;
        c.ss_duty = 10'd0;
        c.ss_ms = 16'd0;
        c.stall_prot = 1'b0;
      end
      1: begin
        c.pwm_bits = 5'd16;
        c.ss_duty = 10'd1000;
        c.stall_hold_ms = 16'd0;
      end
      2: begin
        c.pwm_bits = 5'd31;
        c.stall_thr = 12'd0;
      end
      3: begin
        c.pwm_bits = 5'd1;
        c.ss_duty = 10'd1023;
        c.stall_thr = 12'd4095;
      end
      5: c.ss_ms = 16'hFFFF;
      6: c.blanking_ms = 16'hFFFF;
      7: c.stall_hold_ms = 16'hFFFF;
      default: ;
    endcase
    return c;
  endfunction

  // Mostly ticks with current biased over the threshold and run commands
  // with duties near the kick limit; the rest are other commands and noise.
  task automatic send_random_item();
    int unsigned   r;
    int unsigned   thr;
    int unsigned   kd;
    logic [2:0]    f;
    logic [DUTY_W-1:0] d;
    logic [CUR_W-1:0]  c;
    r   = $urandom_range(0, 99);
    thr = 32'(now_cfg.stall_thr);
    kd  = 32'(now_cfg.ss_duty);
    d   = DUTY_W'($urandom_range(0, 1023));
    c   = CUR_W'($urandom_range(0, 4095));
    if (r < 58) begin
      f = FUNC_TICK;
      case ($urandom_range(0, 9))
        0: c = CUR_W'(thr);
        1, 2, 3, 4, 5: c = (thr < 4095) ? CUR_W'($urandom_range(thr + 1, 4095)) : 12'd4095;
        default: ;
      endcase
    end else if (r < 72) begin
      f = FUNC_RUN;
      case ($urandom_range(0, 3))
        1: d = (kd > 1) ? DUTY_W'($urandom_range(1, (kd > 1023 ? 1023 : kd) - 1)) : 10'd1;
        2: d = $urandom_range(0, 1) ? 10'd0 : DUTY_W'($urandom_range(1000, 1023));
        default: ;
      endcase
    end else if (r < 78) begin
      f = FUNC_CLEAR_FAULT;
    end else if (r < 82) begin
      f = FUNC_ENABLE;
    end else if (r < 86) begin
      f = FUNC_COAST;
    end else if (r < 90) begin
      f = FUNC_BRAKE;
    end else if (r < 94) begin
      f = FUNC_DISABLE;
    end else begin
      f = 3'($urandom_range(0, 7));
    end
    push_item(f, d, c);
  endtask

  initial begin
    cfg_t dcfg;
    now_cfg           = '0;
    now_cfg.pwm_bits  = PWM_BITS_RST;
    now_cfg.stall_thr = THR_RST;

    // Hold reset at the start, then release it for the rest of the run.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset settings, every command, duty saturation, unused code.
    push_item(FUNC_TICK, 10'd0, 12'hFFF);
    push_item(FUNC_RUN, 10'd500, 12'd0);
    push_item(FUNC_TICK, 10'd1023, 12'd0);
    push_item(FUNC_RUN, 10'd1023, 12'd0);
    push_item(FUNC_RUN, 10'd0, 12'd0);
    push_item(FUNC_BRAKE, 10'd0, 12'd0);
    push_item(FUNC_COAST, 10'd0, 12'd0);
    push_item(FUNC_DISABLE, 10'd0, 12'd0);
    push_item(FUNC_TICK, 10'd0, 12'd0);
    push_item(FUNC_UNUSED, 10'd1023, 12'hFFF);
    push_item(FUNC_ENABLE, 10'd0, 12'd0);
    push_item(FUNC_CLEAR_FAULT, 10'd0, 12'd0);
    settle();

    // Directed: kick start and its end, blanking, a full stall, the run
    // blocked by the latched fault, clear, and current equal to threshold.
    dcfg               = '0;
    dcfg.pwm_bits      = 5'd16;
    dcfg.ss_enable     = 1'b1;
    dcfg.ss_duty       = 10'd300;
    dcfg.ss_ms         = 16'd3;
    dcfg.blanking_ms   = 16'd2;
    dcfg.stall_hold_ms = 16'd2;
    dcfg.stall_thr     = 12'd2000;
    dcfg.stall_prot    = 1'b1;
    apply_settings(dcfg);
    push_item(FUNC_RUN, 10'd100, 12'd0);
    push_item(FUNC_TICK, 10'd0, 12'd0);
    push_item(FUNC_TICK, 10'd0, 12'd0);
    push_item(FUNC_TICK, 10'd0, 12'd0);
    push_item(FUNC_TICK, 10'd0, 12'hFFF);
    push_item(FUNC_TICK, 10'd0, 12'hFFF);
    push_item(FUNC_TICK, 10'd0, 12'hFFF);
    push_item(FUNC_RUN, 10'd500, 12'd0);
    push_item(FUNC_CLEAR_FAULT, 10'd0, 12'd0);
    push_item(FUNC_RUN, 10'd500, 12'd0);
    push_item(FUNC_TICK, 10'd0, 12'd2000);
    push_item(FUNC_DISABLE, 10'd0, 12'd0);
    push_item(FUNC_RUN, 10'd200, 12'd0);
    push_item(FUNC_TICK, 10'd0, 12'hFFF);
    settle();

    // Random phases: one with no idling on either side, one with a long
    // receiver hold-off right at its start.
    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      apply_settings(pick_settings(ph));
      tx_steady = (ph == 2);
      rx_steady = (ph == 2);
      if (ph == 4) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) send_random_item();
      settle();
    end

    $display("Covered %0d items over %0d register settings, directed and random.",
             items_sent, RAND_PHASES + 2);
    $display("Stall faults raised: %0d; back-pressure hold-off and idle-free stretch run.",
             stalls_seen);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #200000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
